// File: hdl/bcgd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bcgd_pkg;

  localparam int unsigned LenW     = 4;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned MsW      = 16;
  localparam int unsigned CountW   = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 8;

  localparam logic [LenW-1:0]   LEN_MIN    = LenW'(5);
  localparam logic [CountW-1:0] CLICKS_MAX = CountW'(2);

  localparam logic [MsW-1:0] LONG_PRESS_MS_RST   = MsW'(2000);
  localparam logic [MsW-1:0] DBL_CLICK_WIN_RST   = MsW'(1000);
  localparam logic           LONG_PRESS_EN_RST   = 1'b0;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LONG_PRESS_MS  = 2'd0,
    CFG_DBL_CLICK_WIN  = 2'd1,
    CFG_LONG_PRESS_EN  = 2'd2,
    CFG_UNUSED         = 2'd3
  } cfg_idx_t;

endpackage

`default_nettype wire

// File: hdl/button_click_gesture_detector.sv
// Path from input request to result: input register, then result register.
// Throughput: one request per cycle while out_tready does not hold the result; one result per request.
// The input accepts one more request while a result waits to be taken.
// Reset (rst_n low, synchronous): press, click and count state cleared,
// registers back to 2000 ms / 1000 ms / long-press action off, both stages empty.
`timescale 1ns / 1ps
`default_nettype none

module button_click_gesture_detector (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // frame_length [3:0], button_pressed [4], now_ms [36:5], zero [39:37]
  input  wire logic [bcgd_pkg::InDataW-1:0]     in_tdata,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // long_press_request [0], double_click_event [1], activity_pulse [2], zero [7:3]
  output logic [bcgd_pkg::OutDataW-1:0]         out_tdata,
  input  wire logic                             cfg_we,
  input  wire logic [bcgd_pkg::CfgIdxW-1:0]     cfg_index,
  input  wire logic [bcgd_pkg::MsW-1:0]         cfg_wdata
);

  import bcgd_pkg::*;

  logic [MsW-1:0]    long_press_ms_r;
  logic [MsW-1:0]    dbl_win_ms_r;
  logic              long_press_en_r;

  logic              in_valid_r;
  logic [LenW-1:0]   len_r;
  logic              pressed_r;
  logic [TimeW-1:0]  now_r;

  logic [TimeW-1:0]  press_start_r, press_start_nxt;
  logic [TimeW-1:0]  first_click_r, first_click_nxt;
  logic [CountW-1:0] click_cnt_r, click_cnt_nxt;

  logic              out_valid_r;
  logic              lp_r, lp_nxt;
  logic              dc_r, dc_nxt;

  logic              adv;
  logic              fire;
  logic              ps_zero;
  logic [TimeW-1:0]  ps_a;
  logic [CountW-1:0] cc_a;
  logic [CountW-1:0] cc_b;
  logic [TimeW-1:0]  hold_time;
  logic [TimeW-1:0]  since_first;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || adv;
  assign fire      = in_valid_r && adv;

  always_comb begin
    ps_zero     = (press_start_r == '0);
    ps_a        = ps_zero ? now_r : press_start_r;
    cc_a        = click_cnt_r;
    if (ps_zero && (click_cnt_r < CLICKS_MAX)) begin
      cc_a = click_cnt_r + CountW'(1);
    end
    hold_time   = now_r - ps_a;
    since_first = now_r - first_click_r;
    cc_b        = (since_first > TimeW'(dbl_win_ms_r)) ? '0 : click_cnt_r;

    press_start_nxt = press_start_r;
    first_click_nxt = first_click_r;
    click_cnt_nxt   = click_cnt_r;
    lp_nxt          = 1'b0;
    dc_nxt          = 1'b0;

    if (len_r >= LEN_MIN) begin
      if (pressed_r) begin
        press_start_nxt = ps_a;
        click_cnt_nxt   = cc_a;
        if (ps_zero && (cc_a == CountW'(1))) begin
          first_click_nxt = now_r;
        end
        if (hold_time > TimeW'(long_press_ms_r)) begin
          lp_nxt          = long_press_en_r;
          press_start_nxt = '0;
          click_cnt_nxt   = '0;
        end
      end else begin
        press_start_nxt = '0;
        click_cnt_nxt   = cc_b;
        if (cc_b >= CLICKS_MAX) begin
          click_cnt_nxt = '0;
          dc_nxt        = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_press_ms_r <= LONG_PRESS_MS_RST;
      dbl_win_ms_r    <= DBL_CLICK_WIN_RST;
      long_press_en_r <= LONG_PRESS_EN_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_LONG_PRESS_MS: long_press_ms_r <= cfg_wdata;
        CFG_DBL_CLICK_WIN: dbl_win_ms_r    <= cfg_wdata;
        CFG_LONG_PRESS_EN: long_press_en_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      len_r     <= in_tdata[LenW-1:0];
      pressed_r <= in_tdata[LenW];
      now_r     <= in_tdata[LenW+TimeW:LenW+1];
    end
  end

  // gesture state and result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_start_r <= '0;
      first_click_r <= '0;
      click_cnt_r   <= '0;
      out_valid_r   <= 1'b0;
      lp_r          <= 1'b0;
      dc_r          <= 1'b0;
    end else if (adv) begin
      out_valid_r <= in_valid_r;
      if (in_valid_r) begin
        press_start_r <= press_start_nxt;
        first_click_r <= first_click_nxt;
        click_cnt_r   <= click_cnt_nxt;
        lp_r          <= lp_nxt;
        dc_r          <= dc_nxt;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OutDataW-3){1'b0}}, (lp_r | dc_r), dc_r, lp_r};

`ifndef NO_ASSERTIONS
  a_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
    click_cnt_r <= CLICKS_MAX)
    else $error("click count beyond saturation");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(lp_r && dc_r))
    else $error("long press and double click in one result");

  a_dc_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && dc_nxt) |=> (click_cnt_r == '0 && press_start_r == '0))
    else $error("double click left click state behind");

  a_lp_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && lp_nxt) |=> (press_start_r == '0 && click_cnt_r == '0))
    else $error("long press left press state behind");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (in_valid_r && out_valid_r && !out_tready))
    else $error("input stalled with room to advance");
`endif

endmodule

`default_nettype wire
